>>> sv/longest_prefix_match_router_core_assert.svh
// Assertion macros shared by the router core.
`ifndef LONGEST_PREFIX_MATCH_ROUTER_CORE_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define LPMR_ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LPMR_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LPMR_ASSERT_PROP(name, clk, rst, prop, msg)
`define LPMR_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

>>> sv/lpmr_pkg.sv
package lpmr_pkg;

   // Result status codes.
   localparam logic [2:0] STS_ROUTED   = 3'd0;
   localparam logic [2:0] STS_TTL_DROP = 3'd1;
   localparam logic [2:0] STS_NO_ROUTE = 3'd2;
   localparam logic [2:0] STS_BAD_IF   = 3'd3;
   localparam logic [2:0] STS_ADDED    = 3'd4;
   localparam logic [2:0] STS_FULL     = 3'd5;

   localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  length;
      logic        hop_present;
      logic [31:0] hop;
      logic [3:0]  iface;
   } route_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic write_entry;
      logic scan_start;
      logic scan_issue;
      logic load_result;
   } lpmr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic func;
      logic ttl_low;
      logic count_zero;
      logic last_issue;
   } lpmr_sts_type;

   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      for (int i = 0; i < 32; i++) begin
         m[5'(31 - i)] = (6'(i) < len);
      end
      return m;
   endfunction

endpackage

>>> sv/lpmr_ram.sv
module lpmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lpmr_ctrl.sv
module lpmr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lpmr_pkg::lpmr_sts_type sts,
   output lpmr_pkg::lpmr_cmd_type cmd
);
   import lpmr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.func) begin
               cmd.write_entry = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               if (sts.ttl_low || sts.count_zero) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.last_issue) begin
               state_in = S_DRAIN;
            end
         end
         // The compare of the last entry read lands in this cycle.
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/lpmr_dp.sv
module lpmr_dp #(
   parameter int MAX_ROUTES     = 64,
   parameter int MAX_INTERFACES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpmr_pkg::lpmr_cmd_type cmd,
   output lpmr_pkg::lpmr_sts_type sts,
   input  logic                   req_func,
   input  logic [31:0]            req_route_prefix,
   input  logic [5:0]             req_prefix_length,
   input  logic                   req_next_hop_present,
   input  logic [31:0]            req_next_hop_addr,
   input  logic [3:0]             req_interface_num,
   input  logic [31:0]            req_dst_addr,
   input  logic [7:0]             req_ttl_in,
   output logic [2:0]             rsp_status,
   output logic [3:0]             rsp_out_interface,
   output logic [31:0]            rsp_next_hop_out,
   output logic [7:0]             rsp_ttl_out,
   input  logic                   csr_wr_en,
   input  logic [4:0]             csr_wr_data
);
   import lpmr_pkg::*;

   localparam int IDX_W   = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int CNT_W   = $clog2(MAX_ROUTES + 1);
   localparam int MIF_W   = $clog2(MAX_INTERFACES + 1);
   localparam int LIM_W   = (MIF_W > 5) ? MIF_W : 5;
   localparam int ENTRY_W = $bits(route_entry_type);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ROUTES);
   localparam logic [LIM_W-1:0] MAX_IF     = LIM_W'(MAX_INTERFACES);

   // Latched item.
   logic            func_ff;
   route_entry_type add_entry_ff;
   logic [31:0]     dst_ff;
   logic            ttl_low_ff;
   logic [7:0]      ttl_dec_ff;

   logic [CNT_W-1:0] count_ff;
   logic             add_ok_ff;
   logic [4:0]       ifs_in_use_ff;

   logic [IDX_W-1:0] idx_ff;
   logic             cmp_valid_ff;

   logic             found_ff;
   logic [5:0]       best_len_ff;
   logic [3:0]       best_iface_ff;
   logic             best_hop_present_ff;
   logic [31:0]      best_hop_ff;

   logic [2:0]       status_ff;
   logic [3:0]       out_iface_ff;
   logic [31:0]      hop_out_ff;
   logic [7:0]       ttl_out_ff;

   logic             table_full;
   logic [ENTRY_W-1:0] rd_data;
   route_entry_type  rd_entry;
   logic [31:0]      mask;
   logic             hit;
   logic             better;
   logic [LIM_W-1:0] limit;
   logic [LIM_W-1:0] cfg_ext;
   logic [2:0]       status_in;
   logic             routed;

   assign table_full = (count_ff == FULL_COUNT);

   lpmr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ROUTES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_entry && !table_full),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (add_entry_ff),
      .rd_en   (cmd.scan_issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = route_entry_type'(rd_data);
   assign mask     = prefix_mask(rd_entry.length);
   assign hit      = (((rd_entry.prefix ^ dst_ff) & mask) == 32'd0);
   assign better   = !found_ff || (rd_entry.length > best_len_ff);

   assign cfg_ext  = LIM_W'(ifs_in_use_ff);
   assign limit    = (cfg_ext > MAX_IF) ? MAX_IF : cfg_ext;

   assign sts.func       = func_ff;
   assign sts.ttl_low    = ttl_low_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.last_issue = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      priority if (!func_ff) begin
         status_in = add_ok_ff ? STS_ADDED : STS_FULL;
      end else if (ttl_low_ff) begin
         status_in = STS_TTL_DROP;
      end else if (!found_ff) begin
         status_in = STS_NO_ROUTE;
      end else if (LIM_W'(best_iface_ff) >= limit) begin
         status_in = STS_BAD_IF;
      end else begin
         status_in = STS_ROUTED;
      end
   end

   assign routed = (status_in == STS_ROUTED);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ifs_in_use_ff <= 5'd4;
         cmp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ifs_in_use_ff <= csr_wr_data;
         end
         if (cmd.write_entry && !table_full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         cmp_valid_ff <= cmd.scan_issue;
      end
   end

   // Item, scan and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff                  <= req_func;
         add_entry_ff.prefix      <= req_route_prefix;
         add_entry_ff.length      <= (req_prefix_length > MAX_PREFIX_LEN) ?
                                     MAX_PREFIX_LEN : req_prefix_length;
         add_entry_ff.hop_present <= req_next_hop_present;
         add_entry_ff.hop         <= req_next_hop_addr;
         add_entry_ff.iface       <= req_interface_num;
         dst_ff                   <= req_dst_addr;
         ttl_low_ff               <= (req_ttl_in <= 8'd1);
         ttl_dec_ff               <= req_ttl_in - 8'd1;
      end
      if (cmd.write_entry) begin
         add_ok_ff <= !table_full;
      end
      if (cmd.scan_start) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.scan_issue) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmp_valid_ff && hit && better) begin
            found_ff            <= 1'b1;
            best_len_ff         <= rd_entry.length;
            best_iface_ff       <= rd_entry.iface;
            best_hop_present_ff <= rd_entry.hop_present;
            best_hop_ff         <= rd_entry.hop;
         end
      end
      // Only a routed datagram carries a payload; every other result is zero.
      if (cmd.load_result) begin
         status_ff    <= status_in;
         out_iface_ff <= routed ? best_iface_ff : 4'd0;
         hop_out_ff   <= !routed ? 32'd0 : (best_hop_present_ff ? best_hop_ff : dst_ff);
         ttl_out_ff   <= routed ? ttl_dec_ff : 8'd0;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_out_interface = out_iface_ff;
   assign rsp_next_hop_out  = hop_out_ff;
   assign rsp_ttl_out       = ttl_out_ff;

endmodule

>>> sv/longest_prefix_match_router_core.sv
// An add passes through the decode and done states to its result; a route lookup also scans
// each stored route and then drains (no scan when the TTL drops or the table is empty).
// Throughput: one item at a time, one table entry compared per cycle, set by the single
// read port of the route table memory. A result may wait in the output register.
// Reset is synchronous, active high: empties the table, sets interfaces in use to 4.
`include "longest_prefix_match_router_core_assert.svh"

module longest_prefix_match_router_core #(
   parameter int MAX_ROUTES     = 64,
   parameter int MAX_INTERFACES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_route_prefix,
   input  logic [5:0]  req_prefix_length,
   input  logic        req_next_hop_present,
   input  logic [31:0] req_next_hop_addr,
   input  logic [3:0]  req_interface_num,
   input  logic [31:0] req_dst_addr,
   input  logic [7:0]  req_ttl_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_out_interface,
   output logic [31:0] rsp_next_hop_out,
   output logic [7:0]  rsp_ttl_out,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import lpmr_pkg::*;

   lpmr_cmd_type cmd;
   lpmr_sts_type sts;

   lpmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpmr_dp #(
      .MAX_ROUTES     (MAX_ROUTES),
      .MAX_INTERFACES (MAX_INTERFACES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_func             (req_func),
      .req_route_prefix     (req_route_prefix),
      .req_prefix_length    (req_prefix_length),
      .req_next_hop_present (req_next_hop_present),
      .req_next_hop_addr    (req_next_hop_addr),
      .req_interface_num    (req_interface_num),
      .req_dst_addr         (req_dst_addr),
      .req_ttl_in           (req_ttl_in),
      .rsp_status           (rsp_status),
      .rsp_out_interface    (rsp_out_interface),
      .rsp_next_hop_out     (rsp_next_hop_out),
      .rsp_ttl_out          (rsp_ttl_out),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // A transfer in always makes the block busy in the next cycle.
   `LPMR_ASSERT_PROP(a_busy_after_transfer, clock, reset, (req_valid && !req_stall) |=> req_stall, "block not busy after an input transfer")

   // A routed datagram always leaves with a TTL of at least one.
   `LPMR_ASSERT_NEVER(a_routed_ttl, clock, reset, rsp_valid && (rsp_status == STS_ROUTED) && (rsp_ttl_out == 8'd0), "routed result with zero TTL")

   // Every result other than a routed one carries zero payload.
   `LPMR_ASSERT_PROP(a_zero_payload, clock, reset, (rsp_valid && (rsp_status != STS_ROUTED)) |-> ((rsp_out_interface == 4'd0) && (rsp_next_hop_out == 32'd0) && (rsp_ttl_out == 8'd0)), "nonzero payload on a non-routed result")

   // Codes above table full never appear.
   `LPMR_ASSERT_NEVER(a_status_range, clock, reset, rsp_valid && (rsp_status > STS_FULL), "undefined status code")

endmodule
